/* design/bufu_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the buffered uart fifo block
package bufu_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 128;

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  typedef logic [RX_AW-1:0] rx_ptr_t;
  typedef logic [TX_AW-1:0] tx_ptr_t;
  typedef logic [RX_CW-1:0] rx_cnt_t;
  typedef logic [TX_CW-1:0] tx_cnt_t;

  typedef enum logic [2:0] {
    FUNC_LINE_BYTE  = 3'd0,
    FUNC_LINE_READY = 3'd1,
    FUNC_HOST_READ  = 3'd2,
    FUNC_HOST_WRITE = 3'd3,
    FUNC_CLR_ERR    = 3'd4,
    FUNC_CLR_CNT    = 3'd5
  } func_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_FRAME    = 3'd1;
  localparam logic [2:0] ERR_OVERRUN  = 3'd2;
  localparam logic [2:0] ERR_PARITY   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  localparam logic [4:0] FLAG_FRAME    = 5'h01;
  localparam logic [4:0] FLAG_OVERRUN  = 5'h02;
  localparam logic [4:0] FLAG_PARITY   = 5'h04;
  localparam logic [4:0] FLAG_OVERFLOW = 5'h08;
  localparam logic [4:0] FLAG_TIMEOUT  = 5'h10;

  // events of one item that touch the status registers
  typedef struct packed {
    logic       rx_push;
    logic       tx_pop;
    logic       tx_push;
    logic       timeout;
    logic       clr_err;
    logic       clr_cnt;
    logic       tx_idle;
    logic       err_valid;
    logic [2:0] err_code;
  } bufu_evt_t;

  function automatic logic [4:0] err_flag(logic [2:0] code);
    logic [4:0] f;
    case (code)
      ERR_FRAME:    f = FLAG_FRAME;
      ERR_OVERRUN:  f = FLAG_OVERRUN;
      ERR_PARITY:   f = FLAG_PARITY;
      ERR_OVERFLOW: f = FLAG_OVERFLOW;
      default:      f = 5'h00;
    endcase
    return f;
  endfunction

endpackage

/* design/bufu_rx_fifo.sv */
`timescale 1ns / 1ps
// receive ring buffer: byte memory, pointers and fill count
module bufu_rx_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        push_data,
  input  logic              pop,
  output bufu_pkg::rx_cnt_t fill,
  output logic [7:0]        rdata
);
  import bufu_pkg::*;

  logic [7:0] mem [RX_DEPTH];
  rx_ptr_t    wr_ptr;
  rx_ptr_t    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        fill   <= fill + 1'b1;
      end else if (pop) begin
        rd_ptr <= (rd_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        fill   <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/bufu_tx_fifo.sv */
`timescale 1ns / 1ps
// transmit ring buffer: byte memory, pointers and fill count
module bufu_tx_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        push_data,
  input  logic              pop,
  output bufu_pkg::tx_cnt_t fill,
  output logic [7:0]        rdata
);
  import bufu_pkg::*;

  logic [7:0] mem [TX_DEPTH];
  tx_ptr_t    wr_ptr;
  tx_ptr_t    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == TX_AW'(TX_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        fill   <= fill + 1'b1;
      end else if (pop) begin
        rd_ptr <= (rd_ptr == TX_AW'(TX_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        fill   <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/bufu_status.sv */
`timescale 1ns / 1ps
// sticky error flags, latest error code, byte counters and send request
module bufu_status (
  input  logic                clk,
  input  logic                rst,
  input  bufu_pkg::bufu_evt_t evt,
  output logic [4:0]          sticky,
  output logic [2:0]          last_err,
  output logic [15:0]         rx_total,
  output logic [15:0]         tx_total,
  output logic                send_en
);
  import bufu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky   <= '0;
      last_err <= ERR_NONE;
      rx_total <= '0;
      tx_total <= '0;
      send_en  <= 1'b0;
    end else begin
      if (evt.clr_err) begin
        sticky <= '0;
      end else begin
        sticky <= sticky | (evt.err_valid ? err_flag(evt.err_code) : 5'h00)
                         | (evt.timeout ? FLAG_TIMEOUT : 5'h00);
      end
      if (evt.err_valid) begin
        last_err <= evt.err_code;
      end
      if (evt.clr_cnt) begin
        rx_total <= '0;
        tx_total <= '0;
      end else begin
        if (evt.rx_push) begin
          rx_total <= rx_total + 16'd1;
        end
        if (evt.tx_pop) begin
          tx_total <= tx_total + 16'd1;
        end
      end
      if (evt.tx_push) begin
        send_en <= 1'b1;
      end else if (evt.tx_idle) begin
        send_en <= 1'b0;
      end
    end
  end

endmodule

/* design/buffered_uart_fifo_status.sv */
`timescale 1ns / 1ps
// top level: item decode, fifo and status instances, result register
// Each accepted item yields one result, loaded into the output register in
// ST_DONE once that register is free, after the byte read from the receive
// or transmit buffer memory comes out of its registered read port. While
// results are taken as they appear, a new item is accepted every cycle. A
// result left waiting in the output register still lets one more item in;
// that item's result is held back, and further transfers are held off until
// the output register frees. Byte stores are synchronous memories; each item
// reads or writes at most one byte. Their contents are not cleared at reset,
// and fill counts keep unwritten entries from being read.
module buffered_uart_fifo_status (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  byte_in,
  input  logic        frame_error,
  input  logic        overrun_error,
  input  logic        parity_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  read_byte,
  output logic        line_valid,
  output logic [7:0]  line_byte,
  output logic        send_request,
  output logic [7:0]  rx_level,
  output logic [7:0]  tx_space,
  output logic [4:0]  error_bits,
  output logic [2:0]  latest_error,
  output logic [15:0] received_total,
  output logic [15:0] sent_total
);
  import bufu_pkg::*;

  typedef enum logic {ST_IDLE, ST_DONE} state_t;

  state_t     state;
  logic       out_free;
  logic       acc;
  bufu_evt_t  evt;
  logic       rx_pop;
  logic [1:0] acc_status;
  logic       rx_empty;
  logic       rx_full;
  logic       tx_empty;
  logic       tx_full;
  rx_cnt_t    rx_fill;
  tx_cnt_t    tx_fill;
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;
  logic [4:0] sticky;
  logic [2:0] last_err;
  logic [15:0] rx_total;
  logic [15:0] tx_total;
  logic       send_en;
  logic [1:0] pend_status;
  logic       pend_read;
  logic       pend_line;
  tx_cnt_t    tx_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || out_free;
  assign acc      = in_valid && in_ready;

  assign rx_empty = (rx_fill == '0);
  assign rx_full  = (rx_fill == RX_CW'(RX_DEPTH));
  assign tx_empty = (tx_fill == '0);
  assign tx_full  = (tx_fill == TX_CW'(TX_DEPTH));
  assign tx_free  = TX_CW'(TX_DEPTH) - tx_fill;

  always_comb begin
    evt        = '0;
    rx_pop     = 1'b0;
    acc_status = STAT_OK;
    if (acc) begin
      case (func)
        FUNC_LINE_BYTE: begin
          // frame beats overrun beats parity; overflow only for a clean byte
          if (frame_error) begin
            evt.err_valid = 1'b1;
            evt.err_code  = ERR_FRAME;
          end else if (overrun_error) begin
            evt.err_valid = 1'b1;
            evt.err_code  = ERR_OVERRUN;
          end else if (parity_error) begin
            evt.err_valid = 1'b1;
            evt.err_code  = ERR_PARITY;
          end else if (rx_full) begin
            evt.err_valid = 1'b1;
            evt.err_code  = ERR_OVERFLOW;
          end else begin
            evt.rx_push = 1'b1;
          end
        end
        FUNC_LINE_READY: begin
          if (tx_empty) begin
            evt.tx_idle = 1'b1;
          end else begin
            evt.tx_pop = 1'b1;
          end
        end
        FUNC_HOST_READ: begin
          if (rx_empty) begin
            evt.timeout = 1'b1;
            acc_status  = STAT_EMPTY;
          end else begin
            rx_pop = 1'b1;
          end
        end
        FUNC_HOST_WRITE: begin
          if (tx_full) begin
            acc_status = STAT_FULL;
          end else begin
            evt.tx_push = 1'b1;
          end
        end
        FUNC_CLR_ERR: evt.clr_err = 1'b1;
        FUNC_CLR_CNT: evt.clr_cnt = 1'b1;
        default: ;
      endcase
    end
  end

  bufu_rx_fifo u_rx (
    .clk       (clk),
    .rst       (rst),
    .push      (evt.rx_push),
    .push_data (byte_in),
    .pop       (rx_pop),
    .fill      (rx_fill),
    .rdata     (rx_rdata)
  );

  bufu_tx_fifo u_tx (
    .clk       (clk),
    .rst       (rst),
    .push      (evt.tx_push),
    .push_data (byte_in),
    .pop       (evt.tx_pop),
    .fill      (tx_fill),
    .rdata     (tx_rdata)
  );

  bufu_status u_status (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .sticky   (sticky),
    .last_err (last_err),
    .rx_total (rx_total),
    .tx_total (tx_total),
    .send_en  (send_en)
  );

  // state regs already hold post-item values when the result is loaded
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_status <= acc_status;
      pend_read   <= rx_pop;
      pend_line   <= evt.tx_pop;
    end
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= pend_status;
            read_byte      <= pend_read ? rx_rdata : 8'd0;
            line_valid     <= pend_line;
            line_byte      <= pend_line ? tx_rdata : 8'd0;
            send_request   <= send_en;
            rx_level       <= 8'(rx_fill);
            tx_space       <= 8'(tx_free);
            error_bits     <= sticky;
            latest_error   <= last_err;
            received_total <= rx_total;
            sent_total     <= tx_total;
            state          <= acc ? ST_DONE : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rx_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= RX_CW'(RX_DEPTH))
    else $error("receive fill count above depth");

  a_read_drains: assert property (@(posedge clk) disable iff (rst)
    (acc && func == FUNC_HOST_READ && !rx_empty) |=> rx_fill == $past(rx_fill) - 1'b1)
    else $error("successful host read did not drain one byte");

  a_refused_write: assert property (@(posedge clk) disable iff (rst)
    (acc && func == FUNC_HOST_WRITE && tx_full) |=> $stable(tx_fill))
    else $error("refused write changed transmit fill");

  a_result_after_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised without a pending item");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the buffered uart fifo status block
module testbench;
  import bufu_pkg::*;

  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
  localparam int RANDOM_OPS = 1125;
  localparam int SCRIPT_LEN = 24;

  localparam logic [1:0] RDY_ALWAYS = 2'd0;
  localparam logic [1:0] RDY_MASK   = 2'd1;
  localparam logic [1:0] RDY_RANDOM = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data;
    logic       fe;
    logic       oe;
    logic       pe;
  } fifo_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic        line_valid;
    logic [7:0]  line_byte;
    logic        send_request;
    logic [7:0]  rx_level;
    logic [7:0]  tx_space;
    logic [4:0]  error_bits;
    logic [2:0]  latest_error;
    logic [15:0] received_total;
    logic [15:0] sent_total;
  } fifo_status_t;

  typedef struct packed {
    fifo_op_t     op;
    logic         pinned;
    fifo_status_t want;
  } script_row_t;

  typedef enum int {PH_MIX, PH_RX_FILL, PH_RX_DRAIN, PH_TX_FILL, PH_TX_DRAIN} phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = FUNC_CLR_ERR;
  logic [7:0]  byte_in = 8'h00;
  logic        frame_error = 1'b0;
  logic        overrun_error = 1'b0;
  logic        parity_error = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic        line_valid;
  logic [7:0]  line_byte;
  logic        send_request;
  logic [7:0]  rx_level;
  logic [7:0]  tx_space;
  logic [4:0]  error_bits;
  logic [2:0]  latest_error;
  logic [15:0] received_total;
  logic [15:0] sent_total;

  buffered_uart_fifo_status u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .byte_in(byte_in), .frame_error(frame_error),
    .overrun_error(overrun_error), .parity_error(parity_error),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .read_byte(read_byte), .line_valid(line_valid),
    .line_byte(line_byte), .send_request(send_request), .rx_level(rx_level),
    .tx_space(tx_space), .error_bits(error_bits), .latest_error(latest_error),
    .received_total(received_total), .sent_total(sent_total)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  rx_mem [RX_DEPTH];
  logic [7:0]  tx_mem [TX_DEPTH];
  int          rx_wr = 0, rx_rd = 0, rx_fill = 0;
  int          tx_wr = 0, tx_rd = 0, tx_fill = 0;
  logic [4:0]  err_sticky = '0;
  logic [2:0]  last_err = ERR_NONE;
  logic [15:0] rx_total = '0;
  logic [15:0] tx_total = '0;
  logic        send_en = 1'b0;

  fifo_status_t pending_status [$];
  int fail_count = 0;
  int results_seen = 0;
  int n_overflow = 0, n_refused = 0, n_timeout = 0, n_line_err = 0, n_rx_full = 0;
  int burst_left = 0;

  function automatic void note_line_error(logic [4:0] flag, logic [2:0] code);
    err_sticky = err_sticky | flag;
    last_err = code;
  endfunction

  function automatic fifo_status_t predict_status(input fifo_op_t r);
    fifo_status_t res;
    res = '0;
    case (r.func)
      FUNC_LINE_BYTE: begin
        if (r.fe) begin
          note_line_error(FLAG_FRAME, ERR_FRAME);
          n_line_err++;
        end else if (r.oe) begin
          note_line_error(FLAG_OVERRUN, ERR_OVERRUN);
          n_line_err++;
        end else if (r.pe) begin
          note_line_error(FLAG_PARITY, ERR_PARITY);
          n_line_err++;
        end else if (rx_fill < RX_DEPTH) begin
          rx_mem[rx_wr] = r.data;
          rx_wr = (rx_wr + 1) % RX_DEPTH;
          rx_fill++;
          rx_total++;
          if (rx_fill == RX_DEPTH) n_rx_full++;
        end else begin
          note_line_error(FLAG_OVERFLOW, ERR_OVERFLOW);
          n_overflow++;
        end
      end
      FUNC_LINE_READY: begin
        if (tx_fill > 0) begin
          res.line_valid = 1'b1;
          res.line_byte = tx_mem[tx_rd];
          tx_rd = (tx_rd + 1) % TX_DEPTH;
          tx_fill--;
          tx_total++;
        end else begin
          send_en = 1'b0;
        end
      end
      FUNC_HOST_READ: begin
        if (rx_fill == 0) begin
          res.status = STAT_EMPTY;
          err_sticky = err_sticky | FLAG_TIMEOUT;
          n_timeout++;
        end else begin
          res.read_byte = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
          rx_fill--;
        end
      end
      FUNC_HOST_WRITE: begin
        if (tx_fill >= TX_DEPTH) begin
          res.status = STAT_FULL;
          n_refused++;
        end else begin
          tx_mem[tx_wr] = r.data;
          tx_wr = (tx_wr + 1) % TX_DEPTH;
          tx_fill++;
          send_en = 1'b1;
        end
      end
      FUNC_CLR_ERR: err_sticky = '0;
      FUNC_CLR_CNT: begin
        rx_total = '0;
        tx_total = '0;
      end
      default: ;
    endcase
    res.send_request   = send_en;
    res.rx_level       = 8'(rx_fill);
    res.tx_space       = 8'(TX_DEPTH - tx_fill);
    res.error_bits     = err_sticky;
    res.latest_error   = last_err;
    res.received_total = rx_total;
    res.sent_total     = tx_total;
    return res;
  endfunction

  // directed script; pinned rows carry a hand-written expectation
  script_row_t script [SCRIPT_LEN] = '{
    '{'{FUNC_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_EMPTY, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0, 8'd128, FLAG_TIMEOUT, ERR_NONE,
        16'd0, 16'd0}},
    // error flags ride along on a non-line item and must be ignored
    '{'{FUNC_LINE_READY, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0, 8'd128, FLAG_TIMEOUT, ERR_NONE,
        16'd0, 16'd0}},
    '{'{FUNC_CLR_ERR, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0, 8'd128, 5'h00, ERR_NONE,
        16'd0, 16'd0}},
    // all three line errors at once: frame wins
    '{'{FUNC_LINE_BYTE, 8'h5A, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0, 8'd128, FLAG_FRAME, ERR_FRAME,
        16'd0, 16'd0}},
    '{'{FUNC_LINE_BYTE, 8'h5A, 1'b0, 1'b1, 1'b1}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0, 8'd128, FLAG_FRAME | FLAG_OVERRUN,
        ERR_OVERRUN, 16'd0, 16'd0}},
    '{'{FUNC_LINE_BYTE, 8'h5A, 1'b0, 1'b0, 1'b1}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0, 8'd128,
        FLAG_FRAME | FLAG_OVERRUN | FLAG_PARITY, ERR_PARITY, 16'd0, 16'd0}},
    '{'{FUNC_LINE_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd1, 8'd128,
        FLAG_FRAME | FLAG_OVERRUN | FLAG_PARITY, ERR_PARITY, 16'd1, 16'd0}},
    '{'{FUNC_LINE_BYTE, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd2, 8'd128,
        FLAG_FRAME | FLAG_OVERRUN | FLAG_PARITY, ERR_PARITY, 16'd2, 16'd0}},
    // clearing the sticky flags keeps the latest error code
    '{'{FUNC_CLR_ERR, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b0, 8'd2, 8'd128, 5'h00, ERR_PARITY,
        16'd2, 16'd0}},
    '{'{FUNC_HOST_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b1, 8'd2, 8'd127, 5'h00, ERR_PARITY,
        16'd2, 16'd0}},
    '{'{FUNC_HOST_WRITE, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b1, 8'd2, 8'd126, 5'h00, ERR_PARITY,
        16'd2, 16'd0}},
    '{'{FUNC_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b1, 8'hFF, 1'b1, 8'd2, 8'd127, 5'h00, ERR_PARITY,
        16'd2, 16'd1}},
    '{'{FUNC_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'hFF, 1'b0, 8'h00, 1'b1, 8'd1, 8'd127, 5'h00, ERR_PARITY,
        16'd2, 16'd1}},
    '{'{FUNC_SPARE_6, 8'hA5, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FUNC_SPARE_7, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{FUNC_CLR_CNT, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 8'h00, 1'b1, 8'd1, 8'd127, 5'h00, ERR_PARITY,
        16'd0, 16'd0}},
    '{'{FUNC_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    // empty transmit buffer drops the send request
    '{'{FUNC_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FUNC_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FUNC_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FUNC_LINE_BYTE, 8'hA5, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FUNC_LINE_BYTE, 8'h3C, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{FUNC_HOST_WRITE, 8'hC3, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FUNC_CLR_CNT, 8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, '0}
  };

  function automatic fifo_op_t pick_op(phase_t ph);
    fifo_op_t r;
    logic [2:0] main_func;
    case (ph)
      PH_RX_FILL:  main_func = FUNC_LINE_BYTE;
      PH_RX_DRAIN: main_func = FUNC_HOST_READ;
      PH_TX_FILL:  main_func = FUNC_HOST_WRITE;
      PH_TX_DRAIN: main_func = FUNC_LINE_READY;
      default:     main_func = FUNC_SPARE_7;
    endcase
    r.data = 8'($urandom_range(0, 255));
    if (ph != PH_MIX && $urandom_range(0, 99) < 80) r.func = main_func;
    else r.func = 3'($urandom_range(0, 7));
    // mostly clean line bytes so the receive buffer can fill
    if (r.func != FUNC_LINE_BYTE || $urandom_range(0, 99) < 15)
      {r.fe, r.oe, r.pe} = 3'($urandom_range(0, 7));
    else
      {r.fe, r.oe, r.pe} = 3'b000;
    return r;
  endfunction

  task automatic send_item(input fifo_op_t r, input logic pinned, input fifo_status_t want);
    fifo_status_t guess;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= r.func;
    byte_in       <= r.data;
    frame_error   <= r.fe;
    overrun_error <= r.oe;
    parity_error  <= r.pe;
    do @(posedge clk); while (!in_ready);
    guess = predict_status(r);
    pending_status.push_back(pinned ? want : guess);
  endtask

  // receiver stall pattern, re-chosen whenever the low six bits of stall_tick are zero
  logic [15:0] stall_tick = '0;
  logic [1:0]  stall_mode = RDY_ALWAYS;
  logic [7:0]  stall_mask = 8'hFF;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[5:0] == 6'd0) begin
      stall_mode <= 2'($urandom_range(0, 2));
      stall_mask <= 8'($urandom_range(1, 255));
    end
    case (stall_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_MASK:   out_ready <= stall_mask[stall_tick[2:0]];
      default:    out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    fifo_status_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        w = pending_status.pop_front();
        check_field("status", w.status, status);
        check_field("read_byte", w.read_byte, read_byte);
        check_field("line_valid", w.line_valid, line_valid);
        check_field("line_byte", w.line_byte, line_byte);
        check_field("send_request", w.send_request, send_request);
        check_field("rx_level", w.rx_level, rx_level);
        check_field("tx_space", w.tx_space, tx_space);
        check_field("error_bits", w.error_bits, error_bits);
        check_field("latest_error", w.latest_error, latest_error);
        check_field("received_total", w.received_total, received_total);
        check_field("sent_total", w.sent_total, sent_total);
        results_seen++;
      end
    end
  end

  initial begin
    fifo_op_t req;
    phase_t   phase;
    int       phase_left;
    int       ops_sent;
    phase = PH_MIX;
    phase_left = 0;
    ops_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_item(script[i].op, script[i].pinned, script[i].want);

    // phases other than the mix phase lean toward filling or draining one buffer so both reach full and empty
    while (ops_sent < RANDOM_OPS) begin
      if (phase_left == 0) begin
        phase = phase_t'($urandom_range(0, 4));
        phase_left = $urandom_range(16, 160);
      end
      phase_left--;
      req = pick_op(phase);
      ops_sent++;
      send_item(req, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d results (%0d scripted, %0d random operations)",
             results_seen, SCRIPT_LEN, ops_sent);
    $display("rx full %0d times, overflows %0d, refused writes %0d, timeouts %0d, line errors %0d",
             n_rx_full, n_overflow, n_refused, n_timeout, n_line_err);
    if (fail_count == 0) begin
      $display("buffered_uart_fifo_status verification clean");
    end else begin
      $display("buffered_uart_fifo_status verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("buffered_uart_fifo_status verification failed");
    $finish;
  end

endmodule
